FILE: hw/rtl/c_operator_maximal_munch_top_macros.svh
// Assertion macros for the top file, which checks its own logic.
// Each macro expects a clock named clk and an active low reset named rst_n in scope.
`ifndef C_OPERATOR_MAXIMAL_MUNCH_TOP_MACROS_SVH
`define C_OPERATOR_MAXIMAL_MUNCH_TOP_MACROS_SVH

// Same-cycle implication.
`define CMM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define CMM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/cmm_pkg.sv
package cmm_pkg;

  localparam int unsigned NumOps   = 35;
  localparam int unsigned MaxRes   = 2;
  localparam int unsigned QDepth   = 4;
  localparam int unsigned QPtrW    = $clog2(QDepth);
  localparam int unsigned QCntW    = $clog2(QDepth + 1);

  // Token kinds.
  localparam logic KIND_OP      = 1'b0;
  localparam logic KIND_SPECIAL = 1'b1;

  // Operator codes, in table order.
  localparam logic [5:0] OP_ADD      = 6'd0;
  localparam logic [5:0] OP_INC      = 6'd1;
  localparam logic [5:0] OP_SUB      = 6'd2;
  localparam logic [5:0] OP_DEC      = 6'd3;
  localparam logic [5:0] OP_DOT      = 6'd4;
  localparam logic [5:0] OP_ARROW    = 6'd5;
  localparam logic [5:0] OP_NOT      = 6'd6;
  localparam logic [5:0] OP_TILDE    = 6'd7;
  localparam logic [5:0] OP_MUL      = 6'd8;
  localparam logic [5:0] OP_DIV      = 6'd9;
  localparam logic [5:0] OP_MOD      = 6'd10;
  localparam logic [5:0] OP_SHL      = 6'd11;
  localparam logic [5:0] OP_SHR      = 6'd12;
  localparam logic [5:0] OP_GT       = 6'd13;
  localparam logic [5:0] OP_GE       = 6'd14;
  localparam logic [5:0] OP_LT       = 6'd15;
  localparam logic [5:0] OP_LE       = 6'd16;
  localparam logic [5:0] OP_EQ       = 6'd17;
  localparam logic [5:0] OP_NE       = 6'd18;
  localparam logic [5:0] OP_AND      = 6'd19;
  localparam logic [5:0] OP_XOR      = 6'd20;
  localparam logic [5:0] OP_OR       = 6'd21;
  localparam logic [5:0] OP_LAND     = 6'd22;
  localparam logic [5:0] OP_LOR      = 6'd23;
  localparam logic [5:0] OP_ADD_ASG  = 6'd24;
  localparam logic [5:0] OP_SUB_ASG  = 6'd25;
  localparam logic [5:0] OP_MUL_ASG  = 6'd26;
  localparam logic [5:0] OP_DIV_ASG  = 6'd27;
  localparam logic [5:0] OP_MOD_ASG  = 6'd28;
  localparam logic [5:0] OP_SHL_ASG  = 6'd29;
  localparam logic [5:0] OP_SHR_ASG  = 6'd30;
  localparam logic [5:0] OP_AND_ASG  = 6'd31;
  localparam logic [5:0] OP_XOR_ASG  = 6'd32;
  localparam logic [5:0] OP_OR_ASG   = 6'd33;
  localparam logic [5:0] OP_ASG      = 6'd34;

  // Character codes.
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_TILDE = 8'h7E;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_CARET = 8'h5E;
  localparam logic [7:0] CH_BAR   = 8'h7C;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;

  typedef struct packed {
    logic       kind;
    logic [5:0] code;
    logic [7:0] chr;
    logic       last;
  } cmm_res_t;

  // Results of one transition, handed to the output queue.
  typedef struct packed {
    logic [1:0] cnt;
    cmm_res_t   r0;
    cmm_res_t   r1;
  } cmm_push_t;

  typedef struct packed {
    logic       hit;
    logic [5:0] code;
  } cmm_match_t;

  // Operator that a single character starts, if any.
  function automatic cmm_match_t op_start(logic [7:0] c);
    cmm_match_t m;
    m.hit  = 1'b1;
    m.code = OP_ADD;
    case (c)
      CH_PLUS:  m.code = OP_ADD;
      CH_MINUS: m.code = OP_SUB;
      CH_DOT:   m.code = OP_DOT;
      CH_BANG:  m.code = OP_NOT;
      CH_TILDE: m.code = OP_TILDE;
      CH_STAR:  m.code = OP_MUL;
      CH_SLASH: m.code = OP_DIV;
      CH_PCT:   m.code = OP_MOD;
      CH_GT:    m.code = OP_GT;
      CH_LT:    m.code = OP_LT;
      CH_AMP:   m.code = OP_AND;
      CH_CARET: m.code = OP_XOR;
      CH_BAR:   m.code = OP_OR;
      CH_EQ:    m.code = OP_ASG;
      default:  m.hit  = 1'b0;
    endcase
    return m;
  endfunction

  // Operator formed by appending a character to a pending operator, if any.
  function automatic cmm_match_t op_extend(logic [5:0] op, logic [7:0] c);
    cmm_match_t m;
    m.hit  = 1'b0;
    m.code = op;
    case (op)
      OP_ADD: begin
        if (c == CH_PLUS) begin m.hit = 1'b1; m.code = OP_INC; end
        else if (c == CH_EQ) begin m.hit = 1'b1; m.code = OP_ADD_ASG; end
      end
      OP_SUB: begin
        if (c == CH_MINUS) begin m.hit = 1'b1; m.code = OP_DEC; end
        else if (c == CH_GT) begin m.hit = 1'b1; m.code = OP_ARROW; end
        else if (c == CH_EQ) begin m.hit = 1'b1; m.code = OP_SUB_ASG; end
      end
      OP_NOT: begin
        if (c == CH_EQ) begin m.hit = 1'b1; m.code = OP_NE; end
      end
      OP_MUL: begin
        if (c == CH_EQ) begin m.hit = 1'b1; m.code = OP_MUL_ASG; end
      end
      OP_DIV: begin
        if (c == CH_EQ) begin m.hit = 1'b1; m.code = OP_DIV_ASG; end
      end
      OP_MOD: begin
        if (c == CH_EQ) begin m.hit = 1'b1; m.code = OP_MOD_ASG; end
      end
      OP_SHL: begin
        if (c == CH_EQ) begin m.hit = 1'b1; m.code = OP_SHL_ASG; end
      end
      OP_SHR: begin
        if (c == CH_EQ) begin m.hit = 1'b1; m.code = OP_SHR_ASG; end
      end
      OP_GT: begin
        if (c == CH_GT) begin m.hit = 1'b1; m.code = OP_SHR; end
        else if (c == CH_EQ) begin m.hit = 1'b1; m.code = OP_GE; end
      end
      OP_LT: begin
        if (c == CH_LT) begin m.hit = 1'b1; m.code = OP_SHL; end
        else if (c == CH_EQ) begin m.hit = 1'b1; m.code = OP_LE; end
      end
      OP_AND: begin
        if (c == CH_AMP) begin m.hit = 1'b1; m.code = OP_LAND; end
        else if (c == CH_EQ) begin m.hit = 1'b1; m.code = OP_AND_ASG; end
      end
      OP_XOR: begin
        if (c == CH_EQ) begin m.hit = 1'b1; m.code = OP_XOR_ASG; end
      end
      OP_OR: begin
        if (c == CH_BAR) begin m.hit = 1'b1; m.code = OP_LOR; end
        else if (c == CH_EQ) begin m.hit = 1'b1; m.code = OP_OR_ASG; end
      end
      OP_ASG: begin
        if (c == CH_EQ) begin m.hit = 1'b1; m.code = OP_EQ; end
      end
      default: m.hit = 1'b0;
    endcase
    return m;
  endfunction

  function automatic logic is_white(logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) ||
           (c == CH_VT) || (c == CH_FF) || (c == CH_CR);
  endfunction

endpackage

FILE: hw/rtl/cmm_core.sv
module cmm_core
  import cmm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  logic [7:0] in_ch,
  input  logic      in_flush_request,
  input  logic      q_space,
  output cmm_push_t push
);

  logic       s1_valid_r;
  logic [7:0] s1_ch_r;
  logic       s1_flush_r;
  logic       pend_valid_r, pend_valid_nxt;
  logic [5:0] pend_op_r, pend_op_nxt;
  logic       fire;
  cmm_match_t ext, start;
  cmm_res_t   op_res, sp_res;
  cmm_push_t  step;

  // The held item moves on only when the queue can take both of its results.
  assign fire     = s1_valid_r && q_space;
  assign in_ready = !s1_valid_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      pend_valid_r <= 1'b0;
      pend_op_r    <= OP_ADD;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (fire) begin
        pend_valid_r <= pend_valid_nxt;
        pend_op_r    <= pend_op_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_ch_r    <= in_ch;
      s1_flush_r <= in_flush_request;
    end
  end

  always_comb begin
    ext   = op_extend(pend_op_r, s1_ch_r);
    start = op_start(s1_ch_r);

    op_res      = '0;
    op_res.kind = KIND_OP;
    op_res.code = pend_op_r;
    sp_res      = '0;
    sp_res.kind = KIND_SPECIAL;
    sp_res.chr  = s1_ch_r;

    step           = '0;
    pend_valid_nxt = pend_valid_r;
    pend_op_nxt    = pend_op_r;

    if (s1_flush_r) begin
      if (pend_valid_r) begin
        step.r0  = op_res;
        step.cnt = 2'd1;
      end
      pend_valid_nxt = 1'b0;
      pend_op_nxt    = OP_ADD;
    end else if (pend_valid_r && ext.hit) begin
      pend_op_nxt = ext.code;
    end else begin
      if (pend_valid_r) begin
        step.r0  = op_res;
        step.cnt = 2'd1;
      end
      pend_valid_nxt = 1'b0;
      pend_op_nxt    = OP_ADD;
      if (start.hit) begin
        pend_valid_nxt = 1'b1;
        pend_op_nxt    = start.code;
      end else if (!is_white(s1_ch_r)) begin
        if (pend_valid_r) begin
          step.r1  = sp_res;
          step.cnt = 2'd2;
        end else begin
          step.r0  = sp_res;
          step.cnt = 2'd1;
        end
      end
    end

    if (step.cnt == 2'd1) begin
      step.r0.last = 1'b1;
    end else if (step.cnt == 2'd2) begin
      step.r1.last = 1'b1;
    end

    push     = step;
    push.cnt = fire ? step.cnt : 2'd0;
  end

endmodule

FILE: hw/rtl/cmm_outq.sv
module cmm_outq
  import cmm_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  cmm_push_t        push,
  output logic             q_space,
  output logic [QCntW-1:0] q_level,
  output logic             out_valid,
  input  logic             out_ready,
  output cmm_res_t         out_res
);

  cmm_res_t           mem_r [QDepth];
  logic [QPtrW-1:0]   wp_r, rp_r;
  logic [QCntW-1:0]   cnt_r, cnt_nxt;
  logic               pop;

  assign out_valid = (cnt_r != '0);
  assign out_res   = mem_r[rp_r];
  assign pop       = out_valid && out_ready;
  assign q_space   = (cnt_r <= QCntW'(QDepth - MaxRes));
  assign q_level   = cnt_r;
  assign cnt_nxt   = cnt_r + QCntW'(push.cnt) - QCntW'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_r + QPtrW'(push.cnt);
      rp_r  <= rp_r + QPtrW'(pop);
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem_r[wp_r] <= push.r0;
    end
    if (push.cnt == 2'd2) begin
      mem_r[wp_r + QPtrW'(1)] <= push.r1;
    end
  end

endmodule

FILE: hw/rtl/c_operator_maximal_munch_top.sv
// Path: an item is held in the input stage register, and its results are then written to
// the result queue, from which they are presented.
// Throughput: one item per cycle while the queue has space; an item with two results takes an output transfer for each.
// The four-entry result queue sets the rate: an item moves on only if two entries are free.
// Reset (rst_n low at a clock edge, synchronous) clears the pending operator and the queue.
module c_operator_maximal_munch_top
  import cmm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_ch,
  input  logic       in_flush_request,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_token_kind,
  output logic [5:0] out_op_code,
  output logic [7:0] out_char_out,
  output logic       out_last
);

`include "c_operator_maximal_munch_top_macros.svh"

  // The core holds one input stage register and the pending operator. Each
  // cycle in which the held character can move on, a small table lookup
  // either grows the pending operator or emits it and then classifies the
  // character as an operator start, whitespace, or a special character; a flush emits it and drops the character.
  cmm_push_t        push;
  logic             q_space;
  logic [QCntW-1:0] q_level;
  cmm_res_t         out_res;

  cmm_core u_core (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_ch            (in_ch),
    .in_flush_request (in_flush_request),
    .q_space          (q_space),
    .push             (push)
  );

  // The result queue decouples the two sides, so a stalled output does not
  // stop input transfers until the queue is close to full.
  cmm_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .q_space   (q_space),
    .q_level   (q_level),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_token_kind = out_res.kind;
  assign out_op_code    = out_res.code;
  assign out_char_out   = out_res.chr;
  assign out_last       = out_res.last;

  // A pair of results is the pending operator followed by a special character.
  `CMM_ASSERT_IMP(a_pair_order, push.cnt == 2'd2, push.r0.kind == KIND_OP && !push.r0.last && push.r1.kind == KIND_SPECIAL && push.r1.last, "bad result pair")
  // The queue never overflows.
  `CMM_ASSERT_IMP(a_q_bound, 1'b1, q_level <= QCntW'(QDepth), "result queue overflow")
  // Unused payload fields of a result are zero.
  `CMM_ASSERT_IMP(a_unused_zero, out_valid, (out_token_kind == KIND_OP) ? (out_char_out == 8'd0) : (out_op_code == 6'd0), "unused field not zero")
  // Results are pushed only when space was reported.
  `CMM_ASSERT_IMP(a_push_space, push.cnt != 2'd0, q_space, "push without space")

endmodule

FILE: tb/c_operator_maximal_munch_top_tb.sv
`timescale 1ns / 100ps

module c_operator_maximal_munch_top_tb;
  import cmm_pkg::*;

  // The run stops here even if the design hangs.
  localparam int unsigned CycleLimit = 400000;

  // Cycles to wait after the last expected token.
  localparam int unsigned DrainCycles = 8;

  // One token as it leaves the design, field for field.
  typedef struct packed {
    logic       kind;
    logic [5:0] code;
    logic [7:0] chr;
    logic       last;
  } token_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_ch = 8'h00;
  logic       in_flush_request = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       out_token_kind;
  logic [5:0] out_op_code;
  logic [7:0] out_char_out;
  logic       out_last;

  c_operator_maximal_munch_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_ch            (in_ch),
    .in_flush_request (in_flush_request),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_token_kind   (out_token_kind),
    .out_op_code      (out_op_code),
    .out_char_out     (out_char_out),
    .out_last         (out_last)
  );

  // Spelling of every operator; the position in this table is its code.
  string op_spelling [NumOps] = '{
    "+", "++", "-", "--", ".", "->", "!", "~", "*", "/", "%",
    "<<", ">>", ">", ">=", "<", "<=", "==", "!=", "&", "^", "|",
    "&&", "||", "+=", "-=", "*=", "/=", "%=", "<<=", ">>=", "&=",
    "^=", "|=", "="
  };

  // Every character that can begin an operator, and every blank.
  string      op_chars = "+-.!~*/%<>=&^|";
  logic [7:0] blank_chars [6] = '{CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR};

  // Our own copy of the tokenizer state: the operator still being grown.
  logic       held_valid = 1'b0;
  logic [5:0] held_op = '0;

  // Tokens that the design still owes us, oldest first.
  token_t tokens_due [$];
  token_t got_token;
  token_t want_token;

  int unsigned error_count = 0;
  int unsigned cycle_count = 0;

  // Percentages of cycles in which the sender holds back and the receiver
  // refuses a transfer. The test sequence changes them between phases.
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  // 100 MHz clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: a hung design ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("c_operator_maximal_munch_top: mismatch");
      $finish;
    end
  end

  // The receiver is ready in each cycle unless a random stall is drawn.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Returns the code of the operator spelled as prefix followed by c, or -1
  // if there is none. A NUL byte never matches, since no spelling holds one.
  function automatic int find_spelling(string prefix, logic [7:0] c);
    string s;
    for (int i = 0; i < NumOps; i++) begin
      s = op_spelling[i];
      if (s.len() == prefix.len() + 1 && s.substr(0, prefix.len() - 1) == prefix &&
          s[prefix.len()] == c) begin
        return i;
      end
    end
    return -1;
  endfunction

  function automatic logic is_blank(logic [7:0] c);
    return c inside {CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR};
  endfunction

  // Advances our tokenizer state by one character or flush and queues the
  // tokens that this transfer must produce, marking the final one as last.
  function automatic void munch_char(logic [7:0] c, logic flush);
    token_t emitted [2];
    int     n;
    int     grown;
    int     begun;
    n = 0;
    grown = -1;
    if (flush) begin
      // A flush emits whatever is held; the character is ignored.
      if (held_valid) begin
        emitted[n] = '{KIND_OP, held_op, 8'h00, 1'b0};
        n++;
      end
      held_valid = 1'b0;
      held_op = '0;
    end else begin
      if (held_valid) begin
        grown = find_spelling(op_spelling[held_op], c);
      end
      if (grown >= 0) begin
        // The longer operator still matches: keep growing, emit nothing.
        held_op = grown[5:0];
      end else begin
        if (held_valid) begin
          emitted[n] = '{KIND_OP, held_op, 8'h00, 1'b0};
          n++;
          held_valid = 1'b0;
          held_op = '0;
        end
        begun = find_spelling("", c);
        if (begun >= 0) begin
          held_valid = 1'b1;
          held_op = begun[5:0];
        end else if (!is_blank(c)) begin
          emitted[n] = '{KIND_SPECIAL, 6'd0, c, 1'b0};
          n++;
        end
      end
    end
    for (int i = 0; i < n; i++) begin
      emitted[i].last = (i == n - 1);
      tokens_due.push_back(emitted[i]);
    end
  endfunction

  function automatic void compare_field(string field, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected 0x%0h, got 0x%0h", $time, field, want, got);
      error_count++;
    end
  endfunction

  // Each output transfer is checked against the oldest token still owed.
  // Outputs and out_ready are read at the edge, before anything updates.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      got_token = '{out_token_kind, out_op_code, out_char_out, out_last};
      if (tokens_due.size() == 0) begin
        $display("%0t: unexpected token, expected none, got kind %0d code %0d char 0x%0h",
                 $time, got_token.kind, got_token.code, got_token.chr);
        error_count++;
      end else begin
        want_token = tokens_due.pop_front();
        compare_field("token_kind", want_token.kind, got_token.kind);
        compare_field("op_code", want_token.code, got_token.code);
        compare_field("char_out", want_token.chr, got_token.chr);
        compare_field("last", want_token.last, got_token.last);
      end
    end
  end

  // Offers one character (or a flush) and waits for its transfer. Random idle
  // cycles come first, so gaps land between any two transfers. Valid stays
  // high from one item to the next when no gap is drawn.
  task automatic send_char(input logic [7:0] c, input logic flush);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_ch <= c;
    in_flush_request <= flush;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    munch_char(c, flush);
  endtask

  task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  // A flush with nothing held gives no token, and its character is ignored.
  // A flush with an operator held emits just that operator.
  task automatic test_flush();
    send_char(8'hA5, 1'b1);
    send_char(CH_PLUS, 1'b0);
    send_char(8'h00, 1'b1);
  endtask

  // Byte extremes: NUL, DEL and the high half all pass through as specials.
  task automatic test_byte_extremes();
    send_char(8'h00, 1'b0);
    send_char(8'hFF, 1'b0);
    send_char(8'h80, 1'b0);
    send_char(8'h7F, 1'b0);
  endtask

  // Blanks end a held operator and are then dropped; with nothing held they
  // give no token at all.
  task automatic test_blanks();
    send_char(CH_MINUS, 1'b0);
    foreach (blank_chars[i]) begin
      send_char(blank_chars[i], 1'b0);
    end
  endtask

  // One character that both ends an operator and passes through as a special
  // gives two tokens from one transfer.
  task automatic test_two_tokens();
    send_char(CH_STAR, 1'b0);
    send_char(8'h40, 1'b0);
  endtask

  // Longest match: a three character operator, then an operator that begins
  // right where the previous one stopped growing.
  task automatic test_longest_match();
    send_char(CH_LT, 1'b0);
    send_char(CH_LT, 1'b0);
    send_char(CH_EQ, 1'b0);
    send_char(CH_EQ, 1'b0);
    send_char(CH_EQ, 1'b0);
    send_char(CH_PLUS, 1'b0);
    send_char(CH_MINUS, 1'b0);
    send_char(CH_GT, 1'b0);
    send_char(CH_GT, 1'b0);
    send_char(8'h00, 1'b1);
  endtask

  // Every operator spelled out once, in shuffled order, each followed by a
  // random separator or by nothing, so neighbors may merge.
  task automatic test_all_operators();
    int    order [NumOps];
    string s;
    foreach (order[i]) begin
      order[i] = i;
    end
    order.shuffle();
    foreach (order[i]) begin
      s = op_spelling[order[i]];
      for (int k = 0; k < s.len(); k++) begin
        send_char(s[k], 1'b0);
      end
      case ($urandom_range(3))
        0: send_char(8'($urandom_range(255)), 1'b1);
        1: send_char(blank_chars[$urandom_range(5)], 1'b0);
        2: send_char(8'($urandom_range(8'h7E, 8'h21)), 1'b0);
        default: ;
      endcase
    end
  endtask

  // Mostly operator characters, so that operators grow and break often, with
  // blanks, other printable text, arbitrary bytes and occasional flushes.
  function automatic logic [7:0] pick_char();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 60) begin
      return op_chars[$urandom_range(op_chars.len() - 1)];
    end else if (r < 72) begin
      return blank_chars[$urandom_range(5)];
    end else if (r < 88) begin
      return 8'($urandom_range(8'h7E, 8'h21));
    end
    return 8'($urandom_range(255));
  endfunction

  task automatic test_random_text(input int unsigned count);
    repeat (count) begin
      send_char(pick_char(), ($urandom_range(19) == 0));
    end
  endtask

  initial begin
    // Hold the synchronous reset, then release it.
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed cases run with the receiver stalling now and then.
    set_idling(0, 30);
    test_flush();
    test_byte_extremes();
    test_blanks();
    test_two_tokens();
    test_longest_match();

    set_idling(13, 13);
    test_all_operators();

    // Random text under each idling pattern in turn.
    set_idling(0, 0);
    test_random_text(220);
    set_idling(62, 0);
    test_random_text(220);
    set_idling(0, 62);
    test_random_text(220);
    set_idling(13, 13);
    test_random_text(220);

    // Flush whatever is still held so that every token comes out.
    send_char(8'h00, 1'b1);
    in_valid <= 1'b0;

    while (tokens_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (DrainCycles) @(posedge clk);

    if (error_count == 0 && tokens_due.size() == 0) begin
      $display("c_operator_maximal_munch_top: match");
    end else begin
      $display("c_operator_maximal_munch_top: mismatch");
    end
    $finish;
  end

endmodule
